// File: src/vtce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtce_pkg
// Shared types and constants of the vector terminal coordinate encoder.
// ----------------------------------------------------------------------------
package vtce_pkg;

  // command codes of the input channel
  typedef enum logic [1:0] {
    ACT_MOVE  = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_ERASE = 2'd2,
    ACT_LEAVE = 2'd3
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE_4014 = 2'd0,
    CFG_AXIS_SWAP = 2'd1,
    CFG_SCALE_Q8  = 2'd2
  } cfg_idx_t;

  // live configuration seen by the front end
  typedef struct packed {
    logic        mode_4014;
    logic        axis_swap;
    logic [15:0] scale_q8;
  } cfg_t;

  // one classified command travelling from front to back
  typedef struct packed {
    action_t    action;
    logic       big;
    logic [4:0] hiy;
    logic [3:0] ex;
    logic [4:0] ly;
    logic [4:0] hix;
    logic [4:0] lx;
  } entry_t;

  localparam int unsigned RUN_MAX = 8;

  localparam logic [7:0] BYTE_GS  = 8'h1d;
  localparam logic [7:0] BYTE_US  = 8'h1f;
  localparam logic [7:0] BYTE_ESC = 8'h1b;
  localparam logic [7:0] BYTE_FF  = 8'h0c;
  localparam logic [7:0] TAG_HI   = 8'h20;
  localparam logic [7:0] TAG_EX   = 8'h60;
  localparam logic [7:0] TAG_LOY  = 8'h60;
  localparam logic [7:0] TAG_LOX  = 8'h40;

  localparam logic [11:0] LIMIT_4014 = 12'd4095;
  localparam logic [11:0] LIMIT_4010 = 12'd1023;
  localparam logic [15:0] SCALE_ONE  = 16'd256;
  localparam logic [19:0] ROUND_HALF = 20'd128;

endpackage

// File: src/vtce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtce_front
// Accepts commands, scales the coordinates and splits them into address fields.
// ----------------------------------------------------------------------------
module vtce_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vtce_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [15:0]          in_x_coord,
  input  logic [15:0]          in_y_coord,
  output logic                 push_valid,
  input  logic                 push_ready,
  output vtce_pkg::entry_t     push_data
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  vtce_pkg::action_t s1_action_r;
  logic [19:0]       s1_px_r;
  logic [19:0]       s1_py_r;
  logic [15:0]       scale_eff;
  logic [31:0]       prod_x;
  logic [31:0]       prod_y;
  logic [19:0]       rnd_x;
  logic [19:0]       rnd_y;
  logic [11:0]       sx;
  logic [11:0]       sy;
  logic [11:0]       dev_x;
  logic [11:0]       dev_y;
  logic [11:0]       limit;
  logic              in_acc;

  // scale of zero acts as unity
  assign scale_eff = (cfg.scale_q8 == 16'd0) ? vtce_pkg::SCALE_ONE : cfg.scale_q8;
  assign prod_x    = in_x_coord * scale_eff;
  assign prod_y    = in_y_coord * scale_eff;

  assign in_ready  = !s1_valid_r || push_ready;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // only the low 20 product bits reach the 12 device bits
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= vtce_pkg::action_t'(in_action);
      s1_px_r     <= prod_x[19:0];
      s1_py_r     <= prod_y[19:0];
    end
  end

  assign rnd_x = s1_px_r + vtce_pkg::ROUND_HALF;
  assign rnd_y = s1_py_r + vtce_pkg::ROUND_HALF;
  assign sx    = rnd_x[19:8];
  assign sy    = rnd_y[19:8];
  assign limit = cfg.mode_4014 ? vtce_pkg::LIMIT_4014 : vtce_pkg::LIMIT_4010;

  always_comb begin
    if (cfg.axis_swap) begin
      dev_y = sx;
      dev_x = limit - sy;
    end else begin
      dev_y = sy;
      dev_x = sx;
    end
  end

  always_comb begin
    push_data        = '0;
    push_data.action = s1_action_r;
    push_data.big    = cfg.mode_4014;
    if (cfg.mode_4014) begin
      push_data.ex  = {dev_y[1:0], dev_x[1:0]};
      push_data.hix = dev_x[11:7];
      push_data.hiy = dev_y[11:7];
      push_data.lx  = dev_x[6:2];
      push_data.ly  = dev_y[6:2];
    end else begin
      push_data.hix = dev_x[9:5];
      push_data.hiy = dev_y[9:5];
      push_data.lx  = dev_x[4:0];
      push_data.ly  = dev_y[4:0];
    end
  end

  assign push_valid = s1_valid_r;

endmodule

// File: src/vtce_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtce_fifo
// Short register queue between the front end and the byte emitter.
// ----------------------------------------------------------------------------
module vtce_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW-1:0]    rd_ptr_nxt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: src/vtce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtce_back
// Tracks terminal state, builds each command's byte run and shifts it out.
// ----------------------------------------------------------------------------
module vtce_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  vtce_pkg::entry_t pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run
);

  localparam int unsigned NSLOT = 11;

  logic [7:0] run_r   [vtce_pkg::RUN_MAX];
  logic [7:0] run_nxt [vtce_pkg::RUN_MAX];
  logic [7:0] built   [vtce_pkg::RUN_MAX];
  logic [3:0] cnt_r;
  logic [3:0] cnt_nxt;
  logic [3:0] built_cnt;

  logic       gon_r,  gon_nxt;
  logic [4:0] hy_r,   hy_nxt;
  logic       hy_v_r, hy_v_nxt;
  logic [3:0] ex_r,   ex_nxt;
  logic       ex_v_r, ex_v_nxt;
  logic [4:0] ly_r,   ly_nxt;
  logic       ly_v_r, ly_v_nxt;
  logic [4:0] hx_r,   hx_nxt;
  logic       hx_v_r, hx_v_nxt;
  logic [4:0] lx_r,   lx_nxt;
  logic       lx_v_r, lx_v_nxt;

  logic             load;
  logic             out_acc;
  logic             is_move, is_point, is_erase, is_leave, enter;
  logic             hy_v, ex_v, ly_v, hx_v;
  logic             hy_en, ex_en, ly_en, hx_en, hx_diff;
  logic [NSLOT-1:0] slot_en;
  logic [7:0]       slot_val [NSLOT];

  assign out_valid       = (cnt_r != 4'd0);
  assign out_byte        = run_r[0];
  assign out_last_of_run = (cnt_r == 4'd1);
  assign out_acc         = out_valid && out_ready;
  assign pop_ready       = (cnt_r == 4'd0) || ((cnt_r == 4'd1) && out_ready);
  assign load            = pop_valid && pop_ready;

  // classify
  assign is_move  = (pop_data.action == vtce_pkg::ACT_MOVE);
  assign is_point = is_move || (pop_data.action == vtce_pkg::ACT_DRAW);
  assign is_erase = (pop_data.action == vtce_pkg::ACT_ERASE);
  assign is_leave = (pop_data.action == vtce_pkg::ACT_LEAVE);
  assign enter    = !gon_r && !is_leave;

  // a move forgets everything sent before encoding its point
  assign hy_v = hy_v_r && !is_move;
  assign ex_v = ex_v_r && !is_move;
  assign ly_v = ly_v_r && !is_move;
  assign hx_v = hx_v_r && !is_move;

  assign hy_en   = is_point && (!hy_v || (hy_r != pop_data.hiy));
  assign ex_en   = is_point && pop_data.big && (!ex_v || (ex_r != pop_data.ex));
  assign hx_diff = !hx_v || (hx_r != pop_data.hix);
  assign ly_en   = is_point && (ex_en || hx_diff || !ly_v || (ly_r != pop_data.ly));
  assign hx_en   = ly_en && hx_diff;

  always_comb begin
    slot_en[0]   = enter;
    slot_val[0]  = vtce_pkg::BYTE_GS;
    slot_en[1]   = enter && lx_v_r;
    slot_val[1]  = vtce_pkg::TAG_LOX + {3'b000, lx_r};
    slot_en[2]   = is_move;
    slot_val[2]  = vtce_pkg::BYTE_GS;
    slot_en[3]   = is_erase;
    slot_val[3]  = vtce_pkg::BYTE_ESC;
    slot_en[4]   = is_erase;
    slot_val[4]  = vtce_pkg::BYTE_FF;
    slot_en[5]   = is_leave && gon_r;
    slot_val[5]  = vtce_pkg::BYTE_US;
    slot_en[6]   = hy_en;
    slot_val[6]  = vtce_pkg::TAG_HI + {3'b000, pop_data.hiy};
    slot_en[7]   = ex_en;
    slot_val[7]  = vtce_pkg::TAG_EX + {4'b0000, pop_data.ex};
    slot_en[8]   = ly_en;
    slot_val[8]  = vtce_pkg::TAG_LOY + {3'b000, pop_data.ly};
    slot_en[9]   = hx_en;
    slot_val[9]  = vtce_pkg::TAG_HI + {3'b000, pop_data.hix};
    slot_en[10]  = is_point;
    slot_val[10] = vtce_pkg::TAG_LOX + {3'b000, pop_data.lx};
  end

  // pack the enabled slots in order
  always_comb begin
    logic [3:0] pos;
    pos = 4'd0;
    for (int i = 0; i < vtce_pkg::RUN_MAX; i++) begin
      built[i] = 8'h00;
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_en[i] && (pos < 4'(vtce_pkg::RUN_MAX))) begin
        built[pos[2:0]] = slot_val[i];
        pos = pos + 4'd1;
      end
    end
    built_cnt = pos;
  end

  always_comb begin
    for (int i = 0; i < vtce_pkg::RUN_MAX; i++) begin
      run_nxt[i] = run_r[i];
    end
    cnt_nxt = cnt_r;
    if (load) begin
      run_nxt = built;
      cnt_nxt = built_cnt;
    end else if (out_acc) begin
      for (int i = 0; i < vtce_pkg::RUN_MAX - 1; i++) begin
        run_nxt[i] = run_r[i + 1];
      end
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_comb begin
    gon_nxt  = gon_r;
    hy_nxt   = hy_r;
    hy_v_nxt = hy_v_r;
    ex_nxt   = ex_r;
    ex_v_nxt = ex_v_r;
    ly_nxt   = ly_r;
    ly_v_nxt = ly_v_r;
    hx_nxt   = hx_r;
    hx_v_nxt = hx_v_r;
    lx_nxt   = lx_r;
    lx_v_nxt = lx_v_r;
    if (load) begin
      gon_nxt = !is_leave;
      if (hy_en) begin
        hy_nxt   = pop_data.hiy;
        hy_v_nxt = 1'b1;
      end else if (is_move) begin
        hy_v_nxt = 1'b0;
      end
      if (ex_en) begin
        ex_nxt   = pop_data.ex;
        ex_v_nxt = 1'b1;
      end else if (is_move) begin
        ex_v_nxt = 1'b0;
      end
      if (ly_en) begin
        ly_nxt   = pop_data.ly;
        ly_v_nxt = 1'b1;
      end else if (is_move) begin
        ly_v_nxt = 1'b0;
      end
      if (hx_en) begin
        hx_nxt   = pop_data.hix;
        hx_v_nxt = 1'b1;
      end else if (is_move) begin
        hx_v_nxt = 1'b0;
      end
      if (is_point) begin
        lx_nxt   = pop_data.lx;
        lx_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 4'd0;
      gon_r  <= 1'b0;
      hy_v_r <= 1'b0;
      ex_v_r <= 1'b0;
      ly_v_r <= 1'b0;
      hx_v_r <= 1'b0;
      lx_v_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      gon_r  <= gon_nxt;
      hy_v_r <= hy_v_nxt;
      ex_v_r <= ex_v_nxt;
      ly_v_r <= ly_v_nxt;
      hx_v_r <= hx_v_nxt;
      lx_v_r <= lx_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    hy_r  <= hy_nxt;
    ex_r  <= ex_nxt;
    ly_r  <= ly_nxt;
    hx_r  <= hx_nxt;
    lx_r  <= lx_nxt;
  end

endmodule

// File: src/vector_terminal_coordinate_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_terminal_coordinate_encoder
// Turns move/draw/erase/leave commands into a 4010/4014 vector byte stream.
// ----------------------------------------------------------------------------
// usage
//   in_*  : one command word per handshake (action, x and y user coordinates)
//   out_* : one terminal byte per word; out_last_of_run marks the final byte
//           a command produced, a leave outside graphics produces none
//   cfg_* : register writes (mode_4014, axis_swap, scale_q8), always ready;
//           write only while the block is drained
// path: with an empty queue the first byte of a command passes the multiply
//   stage, the queue and the emitter's run register before it is on out_byte
// throughput: the emitter sends one byte per cycle while out_ready is high
//   and starts the next run in the cycle the last byte of the previous one
//   leaves; a command has one to eight bytes, and a command with no bytes
//   is still taken from the queue by the emitter
// stall: a stalled receiver holds the current byte; the queue and the
//   multiply stage fill and then in_ready drops
// reset: registers return to 1.0 scale, 4010 mode, no swap; graphics mode
//   off and every remembered byte invalid; no clearing pass is needed
// ----------------------------------------------------------------------------
module vector_terminal_coordinate_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_x_coord,
  input  logic [15:0] in_y_coord,
  // byte channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  vtce_pkg::cfg_t   cfg_r;
  vtce_pkg::cfg_t   cfg_nxt;
  logic             push_valid;
  logic             push_ready;
  vtce_pkg::entry_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  vtce_pkg::entry_t pop_data;

  // register file, writes are registered into cfg_r and always accepted
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vtce_pkg::CFG_MODE_4014: cfg_nxt.mode_4014 = cfg_data[0];
        vtce_pkg::CFG_AXIS_SWAP: cfg_nxt.axis_swap = cfg_data[0];
        vtce_pkg::CFG_SCALE_Q8:  cfg_nxt.scale_q8  = cfg_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_4014 <= 1'b0;
      cfg_r.axis_swap <= 1'b0;
      cfg_r.scale_q8  <= vtce_pkg::SCALE_ONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: scale, optional swap/reflect, split into address fields
  vtce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_x_coord (in_x_coord),
    .in_y_coord (in_y_coord),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  vtce_fifo #(
    .WIDTH ($bits(vtce_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  // back: suppress repeated bytes, track graphics mode, emit the run
  vtce_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTHESIS
  // leave-graphics is a run of its own single byte
  a_us_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte == vtce_pkg::BYTE_US) |-> out_last_of_run)
    else $error("US byte not closing its run");

  // erase ends in form feed, escape is never last
  a_ff_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte == vtce_pkg::BYTE_FF) |-> out_last_of_run)
    else $error("FF byte not closing its run");

  a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte == vtce_pkg::BYTE_ESC) |-> !out_last_of_run)
    else $error("ESC byte closing a run");

  // escape is always followed by form feed in the next word
  a_esc_then_ff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_byte == vtce_pkg::BYTE_ESC)
    |=> out_valid && (out_byte == vtce_pkg::BYTE_FF))
    else $error("ESC not followed by FF");
`endif

endmodule

// File: dv/vector_terminal_coordinate_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_terminal_coordinate_encoder_test
// Self-checking bench for the vector terminal coordinate encoder. Commands go
// in as words with random gaps. A byte-level predictor keeps its own copy of
// the registers, the graphics flag and the remembered address bytes. It
// expands every accepted command into the expected byte run, and each byte
// word that leaves the block is checked against the oldest expectation.
// ----------------------------------------------------------------------------
module vector_terminal_coordinate_encoder_test;

  localparam int WATCHDOG_LIMIT = 4000;  // idle cycles with no handshake at all
  localparam int SETTLE_CYCLES  = 8;     // covers multiply stage, queue and emitter
  localparam int REPORT_CAP     = 40;    // mismatch lines printed, all are counted

  // one expected word of the byte channel
  typedef struct {
    logic [7:0] code;
    logic       last;
  } stream_word_t;

  // a remembered address byte and whether it is known
  typedef struct {
    bit         known;
    logic [4:0] val;
  } remembered_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = vtce_pkg::ACT_LEAVE;
  logic [15:0] in_x_coord = '0;
  logic [15:0] in_y_coord = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = vtce_pkg::CFG_MODE_4014;
  logic [15:0] cfg_data = '0;

  vector_terminal_coordinate_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor state: registers, graphics flag and remembered bytes
  // --------------------------------------------------------------------------
  logic        reg_mode  = 1'b0;
  logic        reg_swap  = 1'b0;
  logic [15:0] reg_scale = vtce_pkg::SCALE_ONE;
  bit          model_graphics = 1'b0;
  remembered_t mem_hiy = '{1'b0, 5'd0};
  remembered_t mem_ex  = '{1'b0, 5'd0};
  remembered_t mem_ly  = '{1'b0, 5'd0};
  remembered_t mem_hix = '{1'b0, 5'd0};
  remembered_t mem_lx  = '{1'b0, 5'd0};

  logic [7:0]   run_bytes[$];        // bytes of the command being predicted
  stream_word_t expected_stream[$];  // byte words still owed by the block

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;                  // no gaps on either side while set

  // user pen position for the random traffic
  logic [15:0] pen_x = '0;
  logic [15:0] pen_y = '0;

  function automatic void put_byte(logic [7:0] b);
    run_bytes.push_back(b);
  endfunction

  function automatic bit differs(remembered_t r, logic [4:0] v);
    return !r.known || r.val != v;
  endfunction

  function automatic void forget_all();
    mem_hiy = '{1'b0, 5'd0};
    mem_ex  = '{1'b0, 5'd0};
    mem_ly  = '{1'b0, 5'd0};
    mem_hix = '{1'b0, 5'd0};
    mem_lx  = '{1'b0, 5'd0};
  endfunction

  // rounded Q8.8 scaling, a zero factor counts as 1.0
  function automatic logic [31:0] scale_user(logic [15:0] v);
    logic [63:0] factor;
    logic [63:0] prod;
    factor = (reg_scale == '0) ? 64'(vtce_pkg::SCALE_ONE) : 64'(reg_scale);
    prod = 64'(v) * factor + 64'(vtce_pkg::ROUND_HALF);
    return 32'(prod >> 8);
  endfunction

  function automatic void enter_graphics();
    if (!model_graphics) begin
      put_byte(vtce_pkg::BYTE_GS);
      // terminal needs the last low-x again to pick up the pen position
      if (mem_lx.known)
        put_byte(8'(mem_lx.val) + vtce_pkg::TAG_LOX);
      model_graphics = 1'b1;
    end
  endfunction

  function automatic void encode_point(logic [15:0] ux, logic [15:0] uy);
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] limit;
    logic [4:0]  hix;
    logic [4:0]  hiy;
    logic [4:0]  lx;
    logic [4:0]  ly;
    logic [4:0]  ex;
    bit          force_ly;
    force_ly = 1'b0;
    limit = reg_mode ? 32'(vtce_pkg::LIMIT_4014) : 32'(vtce_pkg::LIMIT_4010);
    // swapped axes reflect device x, a negative result wraps in 32 bits
    if (reg_swap) begin
      dy = scale_user(ux);
      dx = limit - scale_user(uy);
    end else begin
      dx = scale_user(ux);
      dy = scale_user(uy);
    end
    if (reg_mode) begin
      ex  = {1'b0, dy[1:0], dx[1:0]};
      hix = dx[11:7];
      hiy = dy[11:7];
      lx  = dx[6:2];
      ly  = dy[6:2];
    end else begin
      ex  = '0;
      hix = dx[9:5];
      hiy = dy[9:5];
      lx  = dx[4:0];
      ly  = dy[4:0];
    end
    if (differs(mem_hiy, hiy)) begin
      mem_hiy = '{1'b1, hiy};
      put_byte(8'(hiy) + vtce_pkg::TAG_HI);
    end
    // a stale extra byte only matters in 4014 mode
    if (reg_mode && differs(mem_ex, ex)) begin
      mem_ex = '{1'b1, ex};
      put_byte(8'(ex) + vtce_pkg::TAG_EX);
      force_ly = 1'b1;
    end
    if (force_ly || differs(mem_hix, hix) || differs(mem_ly, ly)) begin
      mem_ly = '{1'b1, ly};
      put_byte(8'(ly) + vtce_pkg::TAG_LOY);
      if (differs(mem_hix, hix)) begin
        mem_hix = '{1'b1, hix};
        put_byte(8'(hix) + vtce_pkg::TAG_HI);
      end
    end
    put_byte(8'(lx) + vtce_pkg::TAG_LOX);
    mem_lx = '{1'b1, lx};
  endfunction

  // expand one accepted command word into its expected byte run
  function automatic void predict_command(vtce_pkg::action_t act, logic [15:0] ux,
                                          logic [15:0] uy);
    run_bytes.delete();
    case (act)
      vtce_pkg::ACT_MOVE: begin
        enter_graphics();
        put_byte(vtce_pkg::BYTE_GS);
        forget_all();
        encode_point(ux, uy);
      end
      vtce_pkg::ACT_DRAW: begin
        enter_graphics();
        encode_point(ux, uy);
      end
      vtce_pkg::ACT_ERASE: begin
        enter_graphics();
        put_byte(vtce_pkg::BYTE_ESC);
        put_byte(vtce_pkg::BYTE_FF);
      end
      default: begin
        // leave outside graphics mode sends nothing
        if (model_graphics) begin
          put_byte(vtce_pkg::BYTE_US);
          model_graphics = 1'b0;
        end
      end
    endcase
    foreach (run_bytes[i])
      expected_stream.push_back('{run_bytes[i], i == run_bytes.size() - 1});
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    if (mismatches < REPORT_CAP)
      $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // every byte word leaving the block is matched against the oldest expectation
  always @(posedge clk) begin
    stream_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_stream.size() == 0) begin
        report_mismatch($sformatf("unexpected byte word 0x%02h", out_byte));
      end else begin
        want = expected_stream.pop_front();
        if (out_byte !== want.code)
          report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                    out_byte, want.code));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("out_last_of_run %b, expected %b on byte 0x%02h",
                                    out_last_of_run, want.last, want.code));
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // idling on both sides
  // --------------------------------------------------------------------------
  // mostly no gap or a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver: bursts of ready with random stalls in between
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // one command word; valid stays up when no gap follows
  task automatic send_command(vtce_pkg::action_t act, logic [15:0] ux,
                              logic [15:0] uy);
    int gap;
    in_valid   <= 1'b1;
    in_action  <= act;
    in_x_coord <= ux;
    in_y_coord <= uy;
    do @(posedge clk); while (!in_ready);
    predict_command(act, ux, uy);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every owed byte is out and the pipe is empty
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_stream.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high, the caller drops it after the last write
  task automatic write_register(vtce_pkg::cfg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vtce_pkg::CFG_MODE_4014: reg_mode  = data[0];
      vtce_pkg::CFG_AXIS_SWAP: reg_swap  = data[0];
      vtce_pkg::CFG_SCALE_Q8:  reg_scale = data;
      default: ;
    endcase
  endtask

  // upper data bits of the one-bit registers are random and must be ignored
  task automatic configure(logic mode, logic swap, logic [15:0] scale);
    settle_block();
    write_register(vtce_pkg::CFG_MODE_4014, {15'($urandom), mode});
    write_register(vtce_pkg::CFG_AXIS_SWAP, {15'($urandom), swap});
    write_register(vtce_pkg::CFG_SCALE_Q8, scale);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // reset values: 4010 mode, no swap, scale 1.0
  task automatic test_power_up_stream();
    send_command(vtce_pkg::ACT_LEAVE, 16'd0, 16'd0);        // not in graphics, no bytes
    send_command(vtce_pkg::ACT_DRAW, 16'd0, 16'd0);         // GS then full address
    send_command(vtce_pkg::ACT_DRAW, 16'd0, 16'd0);         // same point, low-x only
    send_command(vtce_pkg::ACT_DRAW, 16'd1023, 16'd1023);
    send_command(vtce_pkg::ACT_MOVE, 16'd5, 16'd7);         // GS, forget, full address
    send_command(vtce_pkg::ACT_ERASE, 16'hffff, 16'hffff);
    send_command(vtce_pkg::ACT_LEAVE, 16'hffff, 16'h0000);
    send_command(vtce_pkg::ACT_DRAW, 16'd3, 16'd3);         // re-entry repeats low-x
    send_command(vtce_pkg::ACT_LEAVE, 16'h0000, 16'hffff);
  endtask

  // 4014 mode: extra byte, swapped axes with reflection and maximum scale
  task automatic test_wide_swapped();
    configure(1'b1, 1'b1, 16'hffff);
    send_command(vtce_pkg::ACT_DRAW, 16'd0, 16'd0);
    send_command(vtce_pkg::ACT_MOVE, 16'hffff, 16'hffff);   // reflection goes negative
    send_command(vtce_pkg::ACT_DRAW, 16'hffff, 16'd0);
    send_command(vtce_pkg::ACT_DRAW, 16'd1, 16'd1);
    configure(1'b1, 1'b0, vtce_pkg::SCALE_ONE);
    send_command(vtce_pkg::ACT_DRAW, 16'd4095, 16'd4095);
    send_command(vtce_pkg::ACT_DRAW, 16'd4094, 16'd4095);   // extra changes, low-y forced
  endtask

  // zero scale acts as 1.0; smallest scale with reflection in 4010 mode
  task automatic test_scale_corners();
    configure(1'b0, 1'b0, 16'd0);
    send_command(vtce_pkg::ACT_DRAW, 16'd100, 16'd200);
    send_command(vtce_pkg::ACT_MOVE, 16'hffff, 16'd0);
    configure(1'b0, 1'b1, 16'd1);
    send_command(vtce_pkg::ACT_DRAW, 16'd0, 16'hffff);
    send_command(vtce_pkg::ACT_DRAW, 16'h8000, 16'h7fff);
  endtask

  // remembered extra byte survives a trip through 4010 mode
  task automatic test_mode_switch();
    configure(1'b1, 1'b0, vtce_pkg::SCALE_ONE);
    send_command(vtce_pkg::ACT_DRAW, 16'd10, 16'd10);
    configure(1'b0, 1'b0, vtce_pkg::SCALE_ONE);
    send_command(vtce_pkg::ACT_DRAW, 16'd10, 16'd10);
    configure(1'b1, 1'b0, vtce_pkg::SCALE_ONE);
    send_command(vtce_pkg::ACT_DRAW, 16'd10, 16'd10);
  endtask

  // mostly connected polylines with small steps, some jumps, erases and leaves
  task automatic test_random_traffic();
    logic              modes  [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    logic              swaps  [6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    logic [15:0]       scales [6] = '{16'd256, 16'd64, 16'd1000, 16'd1, 16'd256,
                                      16'hffff};
    logic [15:0]       scale;
    int                reach;
    int                step;
    int                pick;
    vtce_pkg::action_t act;
    for (int phase = 0; phase < 6; phase++) begin
      scale = scales[phase];
      if (phase == 4) scale = 16'($urandom_range(1, 65535));
      configure(phase == 4 ? 1'($urandom) : modes[phase],
                phase == 4 ? 1'($urandom) : swaps[phase], scale);
      // user span that maps onto the device area at this scale
      reach = ((reg_mode ? 4096 : 1024) * 256) / int'(scale) + 1;
      if (reach > 65535) reach = 65535;
      calm = (phase == 3);
      pen_x = 16'($urandom_range(0, reach));
      pen_y = 16'($urandom_range(0, reach));
      send_command(vtce_pkg::ACT_MOVE, pen_x, pen_y);
      for (int n = 0; n < 66; n++) begin
        // sender holds off until the block has drained
        if (phase == 1 && n == 33)
          settle_block();
        pick = $urandom_range(0, 99);
        if (pick < 8)       act = vtce_pkg::ACT_MOVE;
        else if (pick < 86) act = vtce_pkg::ACT_DRAW;
        else if (pick < 92) act = vtce_pkg::ACT_ERASE;
        else                act = vtce_pkg::ACT_LEAVE;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          step = $urandom_range(0, 40);
          pen_x = pen_x + 16'($urandom_range(0, 2 * step)) - 16'(step);
          pen_y = pen_y + 16'($urandom_range(0, 2 * step)) - 16'(step);
        end else if (pick < 85) begin
          pen_x = 16'($urandom_range(0, reach));
          pen_y = 16'($urandom_range(0, reach));
        end else begin
          pen_x = 16'($urandom);
          pen_y = 16'($urandom);
        end
        send_command(act, pen_x, pen_y);
      end
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // run
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_up_stream();
    test_wide_swapped();
    test_scale_corners();
    test_mode_switch();
    test_random_traffic();
    settle_block();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
